// ===== sv/assert_macros.svh =====
// Assertion helpers used by the top-level unit. Bodies vanish when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== sv/rti_pkg.sv =====
package rti_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int DIST_WIDTH_DEF  = 32;
	localparam int FRAC_OUT        = 16;
	localparam int MID_DEPTH       = 4;
	localparam int OUT_DEPTH       = 2;
	localparam int CFG_INDEX_W     = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_VERTEX_A,
		CFG_VERTEX_B,
		CFG_VERTEX_C
	} rti_cfg_t;

	// classification handed from the front to the divider
	typedef struct packed {
		logic parallel;
		logic hit;
		logic neg;
	} rti_flags_t;

endpackage

// ===== sv/rti_fifo.sv =====
module rti_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = PTRW + 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wptr_q;
	logic [PTRW-1:0]  rptr_q;
	logic [CNTW-1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= wptr_q + PTRW'(1);
			end
			if (rd_en) begin
				rptr_q <= rptr_q + PTRW'(1);
			end
			cnt_q <= cnt_q + CNTW'(wr_en) - CNTW'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	assign rd_data = mem_q[rptr_q];
	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CNTW'(DEPTH));

endmodule

// ===== sv/rti_front.sv =====
module rti_front #(
	parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic signed [COORD_WIDTH-1:0] origin [3],
	input  logic signed [COORD_WIDTH-1:0] dir [3],
	input  logic [3*COORD_WIDTH-1:0]      vertex_a,
	input  logic [3*COORD_WIDTH-1:0]      vertex_b,
	input  logic [3*COORD_WIDTH-1:0]      vertex_c,
	output logic                          out_valid,
	output rti_pkg::rti_flags_t           out_flags,
	output logic [3*COORD_WIDTH+5:0]      out_num,
	output logic [3*COORD_WIDTH+5:0]      out_den
);

	localparam int CW   = COORD_WIDTH;
	localparam int DFW  = CW + 1;
	localparam int PW   = 2 * CW + 2;
	localparam int NRMW = 2 * CW + 3;
	localparam int DPW  = 3 * CW + 3;
	localparam int NPW  = 3 * CW + 4;
	localparam int NW   = 3 * CW + 6;
	// cross product terms: component k = t[2k] - t[2k+1], t[p] = u[XA[p]] * v[XB[p]]
	localparam int XA [6] = '{1, 2, 2, 0, 0, 1};
	localparam int XB [6] = '{2, 1, 0, 2, 1, 0};

	logic signed [CW-1:0]   va [3];
	logic signed [CW-1:0]   vb [3];
	logic signed [CW-1:0]   vc [3];
	logic signed [DFW-1:0]  e1 [3];
	logic signed [DFW-1:0]  e2 [3];
	logic signed [PW-1:0]   nmp_q [6];
	logic signed [NRMW-1:0] n_q [3];

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [CW-1:0]   d_s1 [3];
	logic signed [CW-1:0]   d_s2 [3];
	logic signed [CW-1:0]   d_s3 [3];
	logic signed [DFW-1:0]  pa_s1 [3];
	logic signed [DFW-1:0]  pb_s1 [3];
	logic signed [DFW-1:0]  pc_s1 [3];
	logic signed [DFW-1:0]  pu [3][3];
	logic signed [DFW-1:0]  pv [3][3];
	logic signed [DPW-1:0]  ndp_s2 [3];
	logic signed [NPW-1:0]  nup_s2 [3];
	logic signed [PW-1:0]   cp_s2 [3][6];
	logic signed [NW-1:0]   nd_s3, num_s3, nd_s4, num_s4;
	logic signed [NRMW-1:0] ce_s3 [3][3];
	logic signed [DPW-1:0]  edp_s4 [3][3];
	logic signed [NW-1:0]   es [3];
	logic [2:0]             ok;
	logic                   nd_neg;
	rti_pkg::rti_flags_t    flg_s5;
	logic [NW-1:0]          num_s5, den_s5;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			va[k] = vertex_a[k*CW +: CW];
			vb[k] = vertex_b[k*CW +: CW];
			vc[k] = vertex_c[k*CW +: CW];
			e1[k] = DFW'(vb[k]) - DFW'(va[k]);
			e2[k] = DFW'(vc[k]) - DFW'(va[k]);
		end
	end

	// face normal follows the vertex registers through the product register nmp_q and then n_q
	always_ff @(posedge clk) begin
		for (int p = 0; p < 6; p++) begin
			nmp_q[p] <= PW'(e1[XA[p]]) * PW'(e2[XB[p]]);
		end
		for (int k = 0; k < 3; k++) begin
			n_q[k] <= NRMW'(nmp_q[2*k]) - NRMW'(nmp_q[2*k+1]);
		end
	end

	always_comb begin
		pu[0] = pa_s1; pv[0] = pb_s1;
		pu[1] = pb_s1; pv[1] = pc_s1;
		pu[2] = pc_s1; pv[2] = pa_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		nd_neg = nd_s4[NW-1];
		for (int e = 0; e < 3; e++) begin
			es[e] = NW'(edp_s4[e][0]) + NW'(edp_s4[e][1]) + NW'(edp_s4[e][2]);
			ok[e] = (es[e] == '0) || (es[e][NW-1] == nd_neg);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k]  <= dir[k];
				pa_s1[k] <= DFW'(va[k]) - DFW'(origin[k]);
				pb_s1[k] <= DFW'(vb[k]) - DFW'(origin[k]);
				pc_s1[k] <= DFW'(vc[k]) - DFW'(origin[k]);
				d_s2[k]   <= d_s1[k];
				ndp_s2[k] <= DPW'(d_s1[k]) * DPW'(n_q[k]);
				nup_s2[k] <= NPW'(pa_s1[k]) * NPW'(n_q[k]);
				d_s3[k]   <= d_s2[k];
			end
			for (int e = 0; e < 3; e++) begin
				for (int p = 0; p < 6; p++) begin
					cp_s2[e][p] <= PW'(pu[e][XA[p]]) * PW'(pv[e][XB[p]]);
				end
				for (int k = 0; k < 3; k++) begin
					ce_s3[e][k]  <= NRMW'(cp_s2[e][2*k]) - NRMW'(cp_s2[e][2*k+1]);
					edp_s4[e][k] <= DPW'(d_s3[k]) * DPW'(ce_s3[e][k]);
				end
			end
			nd_s3  <= NW'(ndp_s2[0]) + NW'(ndp_s2[1]) + NW'(ndp_s2[2]);
			num_s3 <= NW'(nup_s2[0]) + NW'(nup_s2[1]) + NW'(nup_s2[2]);
			nd_s4  <= nd_s3;
			num_s4 <= num_s3;
			flg_s5.parallel <= (nd_s4 == '0);
			flg_s5.hit      <= (nd_s4 != '0) && (&ok);
			flg_s5.neg      <= num_s4[NW-1] != nd_neg;
			num_s5 <= num_s4[NW-1] ? NW'(-num_s4) : NW'(num_s4);
			den_s5 <= nd_neg ? NW'(-nd_s4) : NW'(nd_s4);
		end
	end

	assign out_valid = v_s5;
	assign out_flags = flg_s5;
	assign out_num   = num_s5;
	assign out_den   = den_s5;

endmodule

// ===== sv/rti_back.sv =====
module rti_back #(
	parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
	parameter int DIST_WIDTH  = rti_pkg::DIST_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	input  rti_pkg::rti_flags_t          in_flags,
	input  logic [3*COORD_WIDTH+5:0]     in_num,
	input  logic [3*COORD_WIDTH+5:0]     in_den,
	output logic                         out_valid,
	output logic                         out_hit,
	output logic                         out_parallel,
	output logic signed [DIST_WIDTH-1:0] out_distance
);

	localparam int NW   = 3 * COORD_WIDTH + 6;
	localparam int FRAC = rti_pkg::FRAC_OUT;
	localparam int QB   = DIST_WIDTH - 1;
	localparam int RW   = NW + DIST_WIDTH + FRAC;

	logic [RW-1:0]       rem_s [QB+1];
	logic [RW-1:0]       den_s [QB+1];
	logic [QB-1:0]       quo_s [QB+1];
	logic                sat_s [QB+1];
	logic                vld_s [QB+1];
	rti_pkg::rti_flags_t flg_s [QB+1];
	logic [RW-1:0]       num_ext;
	logic [RW-1:0]       lim_ext;

	assign num_ext = RW'({in_num, {FRAC{1'b0}}});
	assign lim_ext = RW'(in_den) << QB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	// saturate when the quotient would need more than QB bits
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= num_ext;
			den_s[0] <= RW'(in_den);
			quo_s[0] <= '0;
			sat_s[0] <= num_ext >= lim_ext;
			flg_s[0] <= in_flags;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [RW-1:0] sub_den;
		logic          ge;

		assign sub_den = den_s[j] << (QB - 1 - j);
		assign ge      = rem_s[j] >= sub_den;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j+1] <= ge ? rem_s[j] - sub_den : rem_s[j];
				quo_s[j+1] <= ge ? quo_s[j] | (QB'(1) << (QB - 1 - j)) : quo_s[j];
				den_s[j+1] <= den_s[j];
				sat_s[j+1] <= sat_s[j];
				flg_s[j+1] <= flg_s[j];
			end
		end
	end

	always_comb begin
		if (flg_s[QB].parallel) begin
			out_distance = '0;
		end else if (sat_s[QB]) begin
			out_distance = flg_s[QB].neg ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
		end else begin
			out_distance = flg_s[QB].neg ? -{1'b0, quo_s[QB]} : {1'b0, quo_s[QB]};
		end
	end

	assign out_valid    = vld_s[QB];
	assign out_hit      = flg_s[QB].hit;
	assign out_parallel = flg_s[QB].parallel;

endmodule

// ===== sv/ray_triangle_intersect_unit.sv =====
// Ray against triangle: plane distance and edge test, one ray per clock while full is low.
// Write the triangle through cfg_we / cfg_index / cfg_data (vertex A, B, C,
// x in the low COORD_WIDTH bits, then y, then z) only while no transaction
// is in flight; allow two cycles before the next ray so the normal settles.
// Input side is a queue: push a ray when full is low. Result side is a queue:
// read hit, parallel and distance while empty is low, and pop to take them.
// Throughput: one ray per cycle while the result queue drains, set by the fully
// pipelined datapath. From the accepting edge of a push to empty falling, a
// ray passes the front input register, four more front stages for the products
// and sums, the mid queue, the divider entry register, one restoring divider
// stage per quotient bit (DIST_WIDTH - 1 of them) for t, and the result queue.
// A stall on pop holds the back pipeline once the result queue is full; the front
// keeps running into the mid queue until that fills, then full rises.
// Reset clears the vertex registers to zero and empties both queues.
// A parallel ray or a degenerate triangle reports parallel=1, hit=0,
// distance=0; out-of-range distances saturate.
`include "assert_macros.svh"

module ray_triangle_intersect_unit #(
	parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
	parameter int DIST_WIDTH  = rti_pkg::DIST_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rti_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [3*COORD_WIDTH-1:0]         cfg_data,
	input  logic                             push,
	output logic                             full,
	input  logic signed [COORD_WIDTH-1:0]    origin_x,
	input  logic signed [COORD_WIDTH-1:0]    origin_y,
	input  logic signed [COORD_WIDTH-1:0]    origin_z,
	input  logic signed [COORD_WIDTH-1:0]    dir_x,
	input  logic signed [COORD_WIDTH-1:0]    dir_y,
	input  logic signed [COORD_WIDTH-1:0]    dir_z,
	output logic                             empty,
	input  logic                             pop,
	output logic                             hit,
	output logic                             parallel,
	output logic signed [DIST_WIDTH-1:0]     distance
);

	localparam int VW   = 3 * COORD_WIDTH;
	localparam int NW   = 3 * COORD_WIDTH + 6;
	localparam int FLW  = $bits(rti_pkg::rti_flags_t);
	localparam int MIDW = FLW + 2 * NW;
	localparam int OUTW = DIST_WIDTH + 2;

	// coordinate bits above bit 63 of a vertex word read as zero
	function automatic logic [VW-1:0] low64_mask();
		logic [VW-1:0] m;
		for (int i = 0; i < VW; i++) begin
			m[i] = (i < 64);
		end
		return m;
	endfunction

	localparam logic [VW-1:0] VMASK = low64_mask();

	logic [VW-1:0]                 vertex_a_q, vertex_b_q, vertex_c_q;
	logic signed [COORD_WIDTH-1:0] origin [3];
	logic signed [COORD_WIDTH-1:0] dir [3];
	logic                          adv_f, adv_b;
	logic                          front_vld;
	rti_pkg::rti_flags_t           front_flg, back_flg;
	logic [NW-1:0]                 front_num, front_den, back_num, back_den;
	logic                          mid_wr, mid_rd, mid_empty, mid_full;
	logic [MIDW-1:0]               mid_rd_data;
	logic                          back_vld, back_hit, back_par;
	logic signed [DIST_WIDTH-1:0]  back_dist;
	logic                          out_wr, out_rd, out_full;
	logic [OUTW-1:0]               out_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_a_q <= '0;
			vertex_b_q <= '0;
			vertex_c_q <= '0;
		end else if (cfg_we) begin
			unique case (rti_pkg::rti_cfg_t'(cfg_index))
				rti_pkg::CFG_VERTEX_A: vertex_a_q <= cfg_data & VMASK;
				rti_pkg::CFG_VERTEX_B: vertex_b_q <= cfg_data & VMASK;
				rti_pkg::CFG_VERTEX_C: vertex_c_q <= cfg_data & VMASK;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	assign origin = '{origin_x, origin_y, origin_z};
	assign dir    = '{dir_x, dir_y, dir_z};

	// hold the front only when the mid queue is full and not draining
	assign mid_rd = adv_b & ~mid_empty;
	assign adv_f  = ~mid_full | mid_rd;
	assign full   = ~adv_f;
	assign mid_wr = adv_f & front_vld;

	// hold the divider only when the result queue is full and not draining
	assign out_rd = pop & ~empty;
	assign adv_b  = ~out_full | out_rd;
	assign out_wr = adv_b & back_vld;

	rti_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv_f),
		.in_valid (push),
		.origin   (origin),
		.dir      (dir),
		.vertex_a (vertex_a_q),
		.vertex_b (vertex_b_q),
		.vertex_c (vertex_c_q),
		.out_valid(front_vld),
		.out_flags(front_flg),
		.out_num  (front_num),
		.out_den  (front_den)
	);

	rti_fifo #(
		.WIDTH(MIDW),
		.DEPTH(rti_pkg::MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mid_wr),
		.wr_data({front_flg, front_num, front_den}),
		.rd_en  (mid_rd),
		.rd_data(mid_rd_data),
		.empty  (mid_empty),
		.full   (mid_full)
	);

	assign back_flg = mid_rd_data[MIDW-1 -: FLW];
	assign back_num = mid_rd_data[2*NW-1 -: NW];
	assign back_den = mid_rd_data[NW-1:0];

	rti_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.DIST_WIDTH (DIST_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv_b),
		.in_valid    (~mid_empty),
		.in_flags    (back_flg),
		.in_num      (back_num),
		.in_den      (back_den),
		.out_valid   (back_vld),
		.out_hit     (back_hit),
		.out_parallel(back_par),
		.out_distance(back_dist)
	);

	rti_fifo #(
		.WIDTH(OUTW),
		.DEPTH(rti_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (out_wr),
		.wr_data({back_hit, back_par, back_dist}),
		.rd_en  (out_rd),
		.rd_data(out_rd_data),
		.empty  (empty),
		.full   (out_full)
	);

	assign hit      = out_rd_data[OUTW-1];
	assign parallel = out_rd_data[OUTW-2];
	assign distance = out_rd_data[DIST_WIDTH-1:0];

	`ASSERT_IMPLIES(a_mid_no_overflow, clk, arst_n, mid_wr && mid_full, mid_rd, "mid queue overflow")
	`ASSERT_IMPLIES(a_out_no_overflow, clk, arst_n, out_wr && out_full, out_rd, "result queue overflow")
	`ASSERT_NEVER(a_parallel_clean, clk, arst_n, !empty && parallel && (hit || distance != '0), "parallel result not clean")

endmodule
